// File: rtl/core/tio_pkg.sv
// Shared constants and codes for the 2-opt tour improver.
package tio_pkg;
  localparam int MAX_CITIES = 64;
  localparam int CITY_W     = $clog2(MAX_CITIES);
  localparam int CNT_W      = CITY_W + 1;
  localparam int DADDR_W    = 2 * CITY_W;
  localparam int DIST_W     = 32;
  localparam int LEN_W      = 38;
  localparam int TRY_W      = 24;
  localparam int STATUS_W   = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = LEN_W;

  localparam logic [KIND_W-1:0] KIND_LOAD_DIST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_TOUR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MOVE      = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_KEPT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LONGER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT  = 2'd2;

  localparam logic [CNT_W-1:0] MIN_CITIES = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_LIMIT  = CNT_W'(MAX_CITIES < 64 ? MAX_CITIES : 64);
  localparam logic [LEN_W-1:0] LEN_MAX    = {LEN_W{1'b1}};
endpackage

// File: rtl/core/tio_ifs.sv
// Request and response channel interfaces.
interface tio_req_if import tio_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CITY_W-1:0] from_city;
  logic [CITY_W-1:0] to_city;
  logic [DIST_W-1:0] edge_distance;
  logic [CITY_W-1:0] slot;
  logic              read_only;
  logic [CITY_W-1:0] first_pos;
  logic [CITY_W-1:0] second_pos;
  modport source (output valid, kind, from_city, to_city, edge_distance, slot,
                  read_only, first_pos, second_pos, input ready);
  modport sink (input valid, kind, from_city, to_city, edge_distance, slot,
                read_only, first_pos, second_pos, output ready);
endinterface

interface tio_rsp_if import tio_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    tour_length;
  logic [CITY_W-1:0]   city_at_slot;
  modport source (output valid, status, tour_length, city_at_slot, input ready);
  modport sink (input valid, status, tour_length, city_at_slot, output ready);
endinterface

// File: rtl/core/two_opt_tour_improver_core.sv
// Top level of the 2-opt tour improver: memories, sequencer and result register.
//
//   channel | dir | word
//   --------+-----+----------------------------------------------------
//   req     | in  | kind, cities, distance, slot, read flag, positions
//   rsp     | out | status, tour_length, city_at_slot
//   cfg     | in  | write enable, register index, data
//
// One word at a time. A distance load writes both directions, a tour load
// one slot, a read fetches the city at a slot; a start walks the tour with
// one tour memory read and one distance read per edge, pipelined. A move is
// checked first; a tried move walks the candidate tour and, when kept, swaps
// the reversed segment pair by pair. Result goes out through a register,
// so the next word is taken while a result waits; a second result stalls in FIN.
// Synchronous reset clears control state and length/try counters; memories
// are not cleared.
module two_opt_tour_improver_core import tio_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  tio_req_if.sink              req,
  tio_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DW1  = 4'd1;
  localparam logic [3:0] S_DW2  = 4'd2;
  localparam logic [3:0] S_TW   = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_WALK = 4'd7;
  localparam logic [3:0] S_SW0  = 4'd8;
  localparam logic [3:0] S_SW1  = 4'd9;
  localparam logic [3:0] S_SW2  = 4'd10;
  localparam logic [3:0] S_SW3  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  // configuration
  logic [CNT_W-1:0] city_count;
  logic [LEN_W-1:0] target_length;
  logic [TRY_W-1:0] try_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count    <= CNT_W'(64);
      target_length <= '0;
      try_limit     <= TRY_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CITY_COUNT: city_count    <= cfg_data[CNT_W-1:0];
        CFG_TARGET:     target_length <= cfg_data[LEN_W-1:0];
        CFG_TRY_LIMIT:  try_limit     <= cfg_data[TRY_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (city_count < MIN_CITIES) n_eff = MIN_CITIES;
    else if (city_count > POS_LIMIT) n_eff = POS_LIMIT;
    else n_eff = city_count;
  end

  // latched word
  logic [CITY_W-1:0] w_from, w_to, w_slot, w_first, w_second;
  logic [DIST_W-1:0] w_dist;

  // memories
  logic [DIST_W-1:0] dist_mem [MAX_CITIES*MAX_CITIES];
  logic [CITY_W-1:0] tour_mem [MAX_CITIES];
  logic              dist_we, tour_we;
  logic [DADDR_W-1:0] dist_waddr, dist_raddr;
  logic [CITY_W-1:0]  tour_waddr, tour_raddr, tour_wdata;
  logic [DIST_W-1:0]  dist_rd;
  logic [CITY_W-1:0]  tour_rd;

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= w_dist;
    dist_rd <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (tour_we) tour_mem[tour_waddr] <= tour_wdata;
    tour_rd <= tour_mem[tour_raddr];
  end

  logic [3:0]          state;
  logic [LEN_W-1:0]    current_length;
  logic [TRY_W-1:0]    try_count;
  logic [STATUS_W-1:0] res_status;
  logic [CITY_W-1:0]   res_city;

  // walker
  logic             rev;
  logic [CNT_W-1:0] idx;
  logic             p1, p1_first, p2;
  logic [CITY_W-1:0] prev_city;
  logic [LEN_W-1:0]  sum;
  logic [LEN_W:0]    sum_wide;
  logic [CITY_W-1:0] map_pos;
  logic [CNT_W-1:0]  mirror;

  // swapper
  logic [CITY_W-1:0] lo, hi, swap_tmp;

  // output register
  logic                ovalid;
  logic [STATUS_W-1:0] o_status;
  logic [LEN_W-1:0]    o_len;
  logic [CITY_W-1:0]   o_city;
  logic                out_free;

  assign out_free  = !ovalid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = ovalid;
  assign rsp.status = o_status;
  assign rsp.tour_length = o_len;
  assign rsp.city_at_slot = o_city;

  // candidate position: mirrored inside the reversed segment
  assign mirror = CNT_W'(w_first) + CNT_W'(w_second) - idx;
  always_comb begin
    if (idx >= n_eff) map_pos = '0;
    else if (rev && idx >= CNT_W'(w_first) && idx <= CNT_W'(w_second))
      map_pos = mirror[CITY_W-1:0];
    else map_pos = idx[CITY_W-1:0];
  end

  assign sum_wide = {1'b0, sum} + (LEN_W+1)'(dist_rd);

  // memory port control
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = {w_from, w_to};
    dist_raddr = {prev_city, tour_rd};
    tour_we    = 1'b0;
    tour_waddr = w_slot;
    tour_wdata = w_from;
    tour_raddr = w_slot;
    unique case (state)
      S_DW1: dist_we = 1'b1;
      S_DW2: begin
        dist_we    = 1'b1;
        dist_waddr = {w_to, w_from};
      end
      S_TW: tour_we = 1'b1;
      S_WALK: tour_raddr = map_pos;
      S_SW0: tour_raddr = lo;
      S_SW1: tour_raddr = hi;
      S_SW2: begin
        tour_we    = 1'b1;
        tour_waddr = lo;
        tour_wdata = tour_rd;
      end
      S_SW3: begin
        tour_we    = 1'b1;
        tour_waddr = hi;
        tour_wdata = swap_tmp;
      end
      default: ;
    endcase
  end

  logic pos_ok;
  assign pos_ok = (w_first != '0) && (w_second > w_first) &&
                  (CNT_W'(w_second) <= n_eff - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      current_length <= '0;
      try_count      <= '0;
      ovalid         <= 1'b0;
      p1             <= 1'b0;
      p2             <= 1'b0;
    end else begin
      // result register: load in FIN, else drop once taken
      if (state == S_FIN && out_free) ovalid <= 1'b1;
      else if (ovalid && rsp.ready) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid) begin
          w_from     <= req.from_city;
          w_to       <= req.to_city;
          w_dist     <= req.edge_distance;
          w_slot     <= req.slot;
          w_first    <= req.first_pos;
          w_second   <= req.second_pos;
          res_status <= ST_DONE;
          res_city   <= '0;
          idx        <= '0;
          sum        <= '0;
          p1         <= 1'b0;
          p2         <= 1'b0;
          unique case (req.kind)
            KIND_LOAD_DIST: state <= S_DW1;
            KIND_LOAD_TOUR: state <= S_TW;
            KIND_START: begin
              rev   <= 1'b0;
              state <= S_WALK;
            end
            KIND_MOVE: state <= req.read_only ? S_RD1 : S_CHK;
            default: state <= S_IDLE;
          endcase
        end
        S_DW1: state <= S_DW2;
        S_DW2: state <= S_FIN;
        S_TW:  state <= S_FIN;
        S_RD1: state <= S_RD2;
        S_RD2: begin
          res_city <= tour_rd;
          state    <= S_FIN;
        end
        S_CHK: begin
          if (current_length <= target_length || try_count >= try_limit) begin
            res_status <= ST_STOPPED;
            state      <= S_FIN;
          end else if (!pos_ok) begin
            res_status <= ST_BAD_POS;
            state      <= S_FIN;
          end else begin
            try_count <= try_count + TRY_W'(1);
            rev       <= 1'b1;
            state     <= S_WALK;
          end
        end
        S_WALK: begin
          // stage 0: tour read for position idx (idx == n closes the cycle)
          if (idx <= n_eff) begin
            idx      <= idx + CNT_W'(1);
            p1       <= 1'b1;
            p1_first <= (idx == '0);
          end else begin
            p1 <= 1'b0;
          end
          // stage 1: city arrives, distance read of the edge into it
          if (p1) begin
            prev_city <= tour_rd;
            p2        <= !p1_first;
          end else begin
            p2 <= 1'b0;
          end
          // stage 2: saturating accumulate
          if (p2) sum <= sum_wide[LEN_W] ? LEN_MAX : sum_wide[LEN_W-1:0];
          if (idx > n_eff && !p1 && !p2) begin
            if (!rev) begin
              current_length <= sum;
              try_count      <= '0;
              state          <= S_FIN;
            end else if (sum < current_length) begin
              current_length <= sum;
              res_status     <= ST_KEPT;
              lo             <= w_first;
              hi             <= w_second;
              state          <= S_SW0;
            end else begin
              res_status <= ST_LONGER;
              state      <= S_FIN;
            end
          end
        end
        S_SW0: state <= (lo < hi) ? S_SW1 : S_FIN;
        S_SW1: begin
          swap_tmp <= tour_rd;
          state    <= S_SW2;
        end
        S_SW2: state <= S_SW3;
        S_SW3: begin
          lo    <= lo + CITY_W'(1);
          hi    <= hi - CITY_W'(1);
          state <= S_SW0;
        end
        S_FIN: if (out_free) begin
          o_status <= res_status;
          o_len    <= current_length;
          o_city   <= res_city;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: test/two_opt_tour_improver_core_tb.sv
// Self-checking testbench for the 2-opt tour improver core.
module two_opt_tour_improver_core_tb;
  import tio_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles in which no word moves on either channel before the run is declared hung
  localparam int STALL_LIMIT = 20000;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES  = 400;
  // tours only use cities below this, so the distance fill stays small
  localparam int CITIES_USED  = 16;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CITY_W-1:0] from_city;
    logic [CITY_W-1:0] to_city;
    logic [DIST_W-1:0] edge_distance;
    logic [CITY_W-1:0] slot;
    logic              read_only;
    logic [CITY_W-1:0] first_pos;
    logic [CITY_W-1:0] second_pos;
  } req_word_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    tour_length;
    logic [CITY_W-1:0]   city_at_slot;
  } rsp_word_t;

  // Mirror of the tour state; predicts one response per request word.
  class tour_scoreboard;
    logic [DIST_W-1:0] dist_tab [MAX_CITIES][MAX_CITIES];
    logic [CITY_W-1:0] order [MAX_CITIES];
    logic [LEN_W-1:0]  length;
    logic [TRY_W-1:0]  tries;
    logic [CNT_W-1:0]  city_count;
    logic [LEN_W-1:0]  target;
    logic [TRY_W-1:0]  try_limit;
    rsp_word_t         pending_results [$];
    int                errors, words_checked, moves_kept, moves_stopped;

    function new();
      length = '0; tries = '0;
      city_count = 64; target = '0; try_limit = 1000;
      errors = 0; words_checked = 0; moves_kept = 0; moves_stopped = 0;
    endfunction

    function int active_n();
      int n;
      n = city_count;
      if (n < 3) n = 3;
      if (n > POS_LIMIT) n = POS_LIMIT;
      return n;
    endfunction

    function logic [LEN_W-1:0] walk_length(input logic [CITY_W-1:0] o [MAX_CITIES], input int n);
      logic [LEN_W:0] total;
      total = '0;
      for (int i = 0; i < n; i++) begin
        total += dist_tab[o[i]][o[(i + 1 < n) ? i + 1 : 0]];
        if (total > LEN_MAX) total = LEN_MAX;
      end
      return total[LEN_W-1:0];
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      case (idx)
        CFG_CITY_COUNT: city_count = val[CNT_W-1:0];
        CFG_TARGET:     target = val[LEN_W-1:0];
        CFG_TRY_LIMIT:  try_limit = val[TRY_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(input req_word_t w);
      rsp_word_t r;
      logic [CITY_W-1:0] cand [MAX_CITIES];
      logic [LEN_W-1:0] new_len;
      int n, lo, hi;
      logic [CITY_W-1:0] t;
      n = active_n();
      r.status = ST_DONE;
      r.city_at_slot = '0;
      case (w.kind)
        KIND_LOAD_DIST: begin
          dist_tab[w.from_city][w.to_city] = w.edge_distance;
          dist_tab[w.to_city][w.from_city] = w.edge_distance;
        end
        KIND_LOAD_TOUR: order[w.slot] = w.from_city;
        KIND_START: begin
          length = walk_length(order, n);
          tries = '0;
        end
        default: begin
          if (w.read_only) begin
            r.city_at_slot = order[w.slot];
          end else if (length <= target || tries >= try_limit) begin
            r.status = ST_STOPPED;
            moves_stopped++;
          end else if (w.first_pos < 1 || w.second_pos <= w.first_pos ||
                       w.second_pos > n - 1) begin
            r.status = ST_BAD_POS;
          end else begin
            tries = tries + 1'b1;
            cand = order;
            lo = w.first_pos; hi = w.second_pos;
            while (lo < hi) begin
              t = cand[lo]; cand[lo] = cand[hi]; cand[hi] = t;
              lo++; hi--;
            end
            new_len = walk_length(cand, n);
            if (new_len < length) begin
              order = cand;
              length = new_len;
              r.status = ST_KEPT;
              moves_kept++;
            end else begin
              r.status = ST_LONGER;
            end
          end
        end
      endcase
      r.tour_length = length;
      pending_results = {pending_results, r};
    endfunction

    function void check_word(input rsp_word_t got);
      rsp_word_t want;
      words_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status=%0d len=%0h city=%0d", $time,
                 got.status, got.tour_length, got.city_at_slot);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.tour_length !== want.tour_length) begin
        errors++;
        $display("%0t: tour_length expected %0h actual %0h", $time,
                 want.tour_length, got.tour_length);
      end
      if (got.city_at_slot !== want.city_at_slot) begin
        errors++;
        $display("%0t: city_at_slot expected %0d actual %0d", $time,
                 want.city_at_slot, got.city_at_slot);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tio_req_if req ();
  tio_rsp_if rsp ();

  two_opt_tour_improver_core DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tour_scoreboard sb;
  int  send_idle_pct, recv_stall_pct;
  // main toggles this to ask the receiver for one long hold-off
  logic hold_toggle;
  int  idle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Everything driven to known values at time zero.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    req.valid = 1'b0; req.kind = '0; req.from_city = '0; req.to_city = '0;
    req.edge_distance = '0; req.slot = '0; req.read_only = 1'b0;
    req.first_pos = '0; req.second_pos = '0;
    rsp.ready = 1'b0;
    hold_toggle = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    sb = new();
  end

  // Response side: sample at the edge, then pick next ready.
  initial begin : rsp_side
    int hold_left;
    logic seen_toggle;
    rsp_word_t got;
    hold_left = 0;
    seen_toggle = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.tour_length = rsp.tour_length;
        got.city_at_slot = rsp.city_at_slot;
        sb.check_word(got);
      end
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) idle_count = 0;
      else idle_count++;
      if (idle_count >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one word and wait for it to be taken; valid stays high on return.
  task automatic send_word(input req_word_t w);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= w.kind;
    req.from_city <= w.from_city;
    req.to_city <= w.to_city;
    req.edge_distance <= w.edge_distance;
    req.slot <= w.slot;
    req.read_only <= w.read_only;
    req.first_pos <= w.first_pos;
    req.second_pos <= w.second_pos;
    do @(posedge clk); while (!(req.valid && req.ready));
    sb.note_word(w);
  endtask

  // Drain all responses, then let the core settle before a register write.
  task automatic wait_idle();
    req.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic req_word_t blank_word(input logic [KIND_W-1:0] k);
    req_word_t w;
    w.kind = k;
    w.from_city = CITY_W'($urandom); w.to_city = CITY_W'($urandom);
    w.edge_distance = $urandom;
    w.slot = CITY_W'($urandom); w.read_only = 1'($urandom);
    w.first_pos = CITY_W'($urandom);
    w.second_pos = CITY_W'($urandom);
    return w;
  endfunction

  function automatic logic [DIST_W-1:0] rand_dist();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return '0;
      2, 3: return $urandom;
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic req_word_t move_word(input int first, input int second);
    req_word_t w;
    w = blank_word(KIND_MOVE);
    w.read_only = 1'b0;
    w.first_pos = CITY_W'(first);
    w.second_pos = CITY_W'(second);
    return w;
  endfunction

  function automatic req_word_t read_word(input int s);
    req_word_t w;
    w = blank_word(KIND_MOVE);
    w.read_only = 1'b1;
    w.slot = CITY_W'(s);
    return w;
  endfunction

  // Mostly well-formed moves between starts; some loads, reads and bad positions.
  function automatic req_word_t random_word();
    req_word_t w;
    int n, f, pick;
    n = sb.active_n();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w = blank_word(KIND_LOAD_DIST);
      w.edge_distance = rand_dist();
    end else if (pick < 16) begin
      w = blank_word(KIND_LOAD_TOUR);
      w.from_city = CITY_W'($urandom_range(0, CITIES_USED - 1));
    end else if (pick < 26) begin
      w = blank_word(KIND_START);
    end else if (pick < 38) begin
      w = read_word($urandom_range(0, 63));
    end else if (pick < 46) begin
      w = move_word($urandom_range(0, 63), $urandom_range(0, 63));
    end else begin
      f = $urandom_range(1, n - 2);
      w = move_word(f, $urandom_range(f + 1, n - 1));
    end
    return w;
  endfunction

  initial begin : main
    req_word_t w;
    int ph, k;
    logic [CNT_W-1:0] phase_count [4];
    logic [TRY_W-1:0] phase_tries [4];
    phase_count = '{7'd64, 7'd127, 7'd0, 7'd12};
    phase_tries = '{24'hFF_FFFF, 24'd1000, 24'd6, 24'd200};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every tour slot and every distance pair among the cities in use,
    // so no lookup hits an unwritten entry.
    for (int s = 0; s < MAX_CITIES; s++) begin
      w = blank_word(KIND_LOAD_TOUR);
      w.slot = CITY_W'(s);
      w.from_city = CITY_W'($urandom_range(0, CITIES_USED - 1));
      send_word(w);
    end
    for (int a = 0; a < CITIES_USED; a++)
      for (int b = a; b < CITIES_USED; b++) begin
        w = blank_word(KIND_LOAD_DIST);
        w.from_city = CITY_W'(a); w.to_city = CITY_W'(b);
        w.edge_distance = rand_dist();
        send_word(w);
      end

    // Directed: before any start, length 0 is at the target, so moves stop.
    send_word(move_word(1, 2));
    send_word(read_word(0));
    send_word(read_word(63));
    wait_idle();
    write_reg(CFG_CITY_COUNT, CFG_W'(5));
    send_word(blank_word(KIND_START));
    send_word(move_word(0, 2));   // first position zero
    send_word(move_word(2, 2));   // empty segment
    send_word(move_word(3, 1));   // reversed order
    send_word(move_word(1, 4));   // whole open segment
    send_word(move_word(2, 3));
    send_word(move_word(1, 5));   // past the last position
    w = blank_word(KIND_LOAD_DIST);
    w.from_city = 63; w.to_city = 0; w.edge_distance = 32'hFFFF_FFFF;
    send_word(w);
    w = blank_word(KIND_LOAD_TOUR);
    w.slot = 63; w.from_city = CITY_W'(CITIES_USED - 1);
    send_word(w);
    send_word(move_word(1, 3));   // stale length after loads
    send_word(read_word(63));
    send_word(blank_word(KIND_START));
    wait_idle();
    write_reg(CFG_TRY_LIMIT, CFG_W'(0));  // no tries at all
    send_word(move_word(1, 2));
    wait_idle();
    write_reg(CFG_TRY_LIMIT, CFG_W'(2));
    write_reg(CFG_TARGET, LEN_MAX);  // target never beaten
    send_word(move_word(1, 2));
    wait_idle();
    write_reg(CFG_TARGET, CFG_W'(0));
    send_word(move_word(1, 2));
    send_word(move_word(2, 4));
    send_word(move_word(1, 3));   // tries used up
    send_word(blank_word(KIND_START));
    send_word(move_word(1, 3));

    // Random phases over register settings and idling patterns.
    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_reg(CFG_CITY_COUNT, CFG_W'(phase_count[ph]));
      write_reg(CFG_TRY_LIMIT, CFG_W'(phase_tries[ph]));
      write_reg(CFG_TARGET, (ph == 3) ? LEN_W'($urandom_range(0, 1 << 22)) : '0);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      send_word(blank_word(KIND_START));
      for (k = 0; k < 70; k++) begin
        // long response hold-off while words keep coming, so the input backs up
        if (ph == 0 && k == 20) hold_toggle <= ~hold_toggle;
        send_word(random_word());
      end
    end

    req.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d response words; %0d moves kept, %0d stopped.",
             sb.words_checked, sb.moves_kept, sb.moves_stopped);
    $display("Covered city counts 3..64, try limits 0..max, target 0..max, four idle mixes.");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
